// ----- rtl/core/ufe_pkg.sv -----
// shared types and constants for the union-find engine
package ufe_pkg;

  localparam int ELEM_W = 10;
  localparam int SIZE_W = 11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FIX,
    ST_SIZE_X,
    ST_SIZE_Y,
    ST_EMIT
  } state_t;

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_UNITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ELEM_W-1:0] first_element;
    logic [ELEM_W-1:0] second_element;
  } req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] root;
    logic [SIZE_W-1:0] component_size;
    logic              merged;
  } rsp_t;

  // write strobes into the two tables
  typedef struct packed {
    logic parent;
    logic size;
  } tbl_wen_t;

endpackage

// ----- rtl/core/ufe_tables.sv -----
// parent and size tables, one write and one registered read port each
module ufe_tables #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  ufe_pkg::tbl_wen_t         wen,
  input  logic [AW-1:0]             p_raddr,
  output logic [AW-1:0]             p_rdata,
  input  logic [AW-1:0]             p_waddr,
  input  logic [AW-1:0]             p_wdata,
  input  logic [AW-1:0]             s_raddr,
  output logic [ufe_pkg::SIZE_W-1:0] s_rdata,
  input  logic [AW-1:0]             s_waddr,
  input  logic [ufe_pkg::SIZE_W-1:0] s_wdata
);

  logic [AW-1:0]              parent_mem [DEPTH];
  logic [ufe_pkg::SIZE_W-1:0] size_mem   [DEPTH];

  // parent table, write data forwarded on an address match
  always_ff @(posedge clk) begin
    if (wen.parent) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    if (wen.parent && (p_waddr == p_raddr)) begin
      p_rdata <= p_wdata;
    end else begin
      p_rdata <= parent_mem[p_raddr];
    end
  end

  // size table, same forwarding
  always_ff @(posedge clk) begin
    if (wen.size) begin
      size_mem[s_waddr] <= s_wdata;
    end
    if (wen.size && (s_waddr == s_raddr)) begin
      s_rdata <= s_wdata;
    end else begin
      s_rdata <= size_mem[s_raddr];
    end
  end

endmodule

// ----- rtl/core/union_find_engine.sv -----
// union-find engine: union by size with full path compression
//
//  channel | signals                  | moves
//  --------+--------------------------+------------------------------------
//  req     | req_valid req_ready req  | operation, first and second element
//  rsp     | rsp_valid rsp_ready rsp  | root, component size, merged flag
//
// A find reads the parent table once per walk step and once per compression
// step of its path to the root; a unite adds a second walk for its second
// element plus a link step when the two roots differ. The single read port of
// the parent table sets this pace.
// After reset a clearing pass initializes the tables; no request is taken
// meanwhile. A finished result waits in the output register while the next
// request is taken; the engine stalls only at its last step.
module union_find_engine #(
  parameter int ELEMENTS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ufe_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ufe_pkg::rsp_t rsp
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int SW = ufe_pkg::SIZE_W;
  localparam int EW = ufe_pkg::ELEM_W;

  ufe_pkg::state_t   state, state_next;
  logic              op, op_next;
  logic [AW-1:0]     b_elem, b_elem_next;
  logic              b_ok, b_ok_next;
  logic              phase, phase_next;
  logic [AW-1:0]     cur, cur_next;
  logic [AW-1:0]     start, start_next;
  logic [AW-1:0]     found, found_next;
  logic [AW-1:0]     x_root, x_root_next;
  logic [AW-1:0]     y_root, y_root_next;
  logic              link, link_next;
  logic [SW-1:0]     sx, sx_next;
  logic [EW-1:0]     res_root, res_root_next;
  logic [SW-1:0]     res_size, res_size_next;
  logic              res_merged, res_merged_next;
  logic [AW-1:0]     clr, clr_next;
  logic              rsp_load;

  ufe_pkg::tbl_wen_t wen;
  logic [AW-1:0]     p_raddr, p_rdata, p_waddr, p_wdata;
  logic [AW-1:0]     s_raddr, s_waddr;
  logic [SW-1:0]     s_rdata, s_wdata;

  logic              fin;
  logic [AW-1:0]     fin_root;
  logic              a_ok;
  logic [AW-1:0]     a_addr;
  logic [SW-1:0]     size_sum;

  assign a_ok     = 32'(req.first_element) < ELEMENTS;
  assign a_addr   = AW'(32'(req.first_element));
  assign size_sum = sx + s_rdata;

  ufe_tables #(
    .DEPTH(ELEMENTS),
    .AW   (AW)
  ) u_tables (
    .clk    (clk),
    .wen    (wen),
    .p_raddr(p_raddr),
    .p_rdata(p_rdata),
    .p_waddr(p_waddr),
    .p_wdata(p_wdata),
    .s_raddr(s_raddr),
    .s_rdata(s_rdata),
    .s_waddr(s_waddr),
    .s_wdata(s_wdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ufe_pkg::ST_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    op         <= op_next;
    b_elem     <= b_elem_next;
    b_ok       <= b_ok_next;
    phase      <= phase_next;
    cur        <= cur_next;
    start      <= start_next;
    found      <= found_next;
    x_root     <= x_root_next;
    y_root     <= y_root_next;
    link       <= link_next;
    sx         <= sx_next;
    res_root   <= res_root_next;
    res_size   <= res_size_next;
    res_merged <= res_merged_next;
    if (rsp_load) begin
      rsp.root           <= res_root;
      rsp.component_size <= res_size;
      rsp.merged         <= res_merged;
    end
  end

  // sequencer: walk, compress, read sizes, link
  always_comb begin
    state_next      = state;
    op_next         = op;
    b_elem_next     = b_elem;
    b_ok_next       = b_ok;
    phase_next      = phase;
    cur_next        = cur;
    start_next      = start;
    found_next      = found;
    x_root_next     = x_root;
    y_root_next     = y_root;
    link_next       = link;
    sx_next         = sx;
    res_root_next   = res_root;
    res_size_next   = res_size;
    res_merged_next = res_merged;
    clr_next        = clr;
    req_ready       = 1'b0;
    rsp_load        = 1'b0;
    wen             = '0;
    p_raddr         = cur;
    p_waddr         = cur;
    p_wdata         = found;
    s_raddr         = x_root;
    s_waddr         = x_root;
    s_wdata         = size_sum;
    fin             = 1'b0;
    fin_root        = found;

    unique case (state)
      // one table entry per cycle back to its reset value
      ufe_pkg::ST_CLEAR: begin
        wen.parent = 1'b1;
        wen.size   = 1'b1;
        p_waddr    = clr;
        p_wdata    = clr;
        s_waddr    = clr;
        s_wdata    = SW'(1);
        clr_next   = clr + AW'(1);
        if (clr == AW'(ELEMENTS - 1)) begin
          state_next = ufe_pkg::ST_IDLE;
        end
      end

      ufe_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next     = req.operation;
          b_elem_next = AW'(32'(req.second_element));
          b_ok_next   = (req.operation == ufe_pkg::OP_UNITE) &&
                        (32'(req.second_element) < ELEMENTS);
          phase_next  = 1'b0;
          if (a_ok) begin
            cur_next   = a_addr;
            start_next = a_addr;
            p_raddr    = a_addr;
            state_next = ufe_pkg::ST_WALK;
          end else begin
            // out-of-range element stands alone
            res_root_next   = req.first_element;
            res_size_next   = SW'(1);
            res_merged_next = 1'b0;
            state_next      = ufe_pkg::ST_EMIT;
          end
        end
      end

      // follow parent links up to the root
      ufe_pkg::ST_WALK: begin
        if (p_rdata == cur) begin
          found_next = cur;
          if (start == cur) begin
            fin      = 1'b1;
            fin_root = cur;
          end else begin
            cur_next   = start;
            p_raddr    = start;
            state_next = ufe_pkg::ST_FIX;
          end
        end else begin
          cur_next = p_rdata;
          p_raddr  = p_rdata;
        end
      end

      // second pass: point each visited node at the root
      ufe_pkg::ST_FIX: begin
        wen.parent = 1'b1;
        if (p_rdata == found) begin
          fin      = 1'b1;
          fin_root = found;
        end else begin
          cur_next = p_rdata;
          p_raddr  = p_rdata;
        end
      end

      ufe_pkg::ST_SIZE_X: begin
        sx_next = s_rdata;
        if (link) begin
          s_raddr    = y_root;
          state_next = ufe_pkg::ST_SIZE_Y;
        end else begin
          res_root_next   = EW'(32'(x_root));
          res_size_next   = s_rdata;
          res_merged_next = 1'b0;
          state_next      = ufe_pkg::ST_EMIT;
        end
      end

      // smaller root goes under the larger, ties keep the first root
      ufe_pkg::ST_SIZE_Y: begin
        wen.parent = 1'b1;
        wen.size   = 1'b1;
        if (sx < s_rdata) begin
          p_waddr       = x_root;
          p_wdata       = y_root;
          s_waddr       = y_root;
          res_root_next = EW'(32'(y_root));
        end else begin
          p_waddr       = y_root;
          p_wdata       = x_root;
          s_waddr       = x_root;
          res_root_next = EW'(32'(x_root));
        end
        res_size_next   = size_sum;
        res_merged_next = 1'b1;
        state_next      = ufe_pkg::ST_EMIT;
      end

      // hand the result to the output register
      ufe_pkg::ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ufe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ufe_pkg::ST_IDLE;
      end
    endcase

    // end of one find: start the second one or go read sizes
    if (fin) begin
      if (!phase) begin
        x_root_next = fin_root;
        if (b_ok && (op == ufe_pkg::OP_UNITE)) begin
          phase_next = 1'b1;
          cur_next   = b_elem;
          start_next = b_elem;
          p_raddr    = b_elem;
          state_next = ufe_pkg::ST_WALK;
        end else begin
          s_raddr    = fin_root;
          link_next  = 1'b0;
          state_next = ufe_pkg::ST_SIZE_X;
        end
      end else begin
        y_root_next = fin_root;
        s_raddr     = x_root;
        link_next   = (fin_root != x_root);
        state_next  = ufe_pkg::ST_SIZE_X;
      end
    end
  end

`ifndef SYNTH
  // the link step only follows a unite of two distinct roots
  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ufe_pkg::ST_SIZE_Y) |-> (link && (x_root != y_root)))
    else $error("link step without two distinct roots");

  // compression never rewrites the root itself
  a_fix_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == ufe_pkg::ST_FIX) |-> (cur != found))
    else $error("compression write aimed at the root");

  // a new result only appears out of the emit step
  a_rsp_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ufe_pkg::ST_EMIT))
    else $error("result raised outside the emit step");

  // no request is taken during the clearing pass
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ufe_pkg::ST_CLEAR) |=> !(($past(req_ready)) && $past(req_valid)))
    else $error("request taken while clearing");
`endif

endmodule

// ----- tb/tb.sv -----
// testbench for the union-find engine: finds and unites checked against a mirrored forest
`timescale 1ns / 100ps

module tb;

  localparam int N_ELEM     = 1024;
  localparam int IDLE_LIMIT = 4000;   // covers the clearing pass and the long receiver hold
  localparam int DRAIN_WAIT = 64;     // longer than a unite over two worst-case paths
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_LEN  = 330;
  localparam int MAX_PRINTS = 40;

  // mirror of the forest plus the answers still owed by the engine
  class forest_scoreboard;
    logic [ufe_pkg::ELEM_W-1:0] parent_of [N_ELEM];
    logic [ufe_pkg::SIZE_W-1:0] set_size [N_ELEM];
    ufe_pkg::rsp_t              expected_answers [$];
    int                         errors;

    function new();
      errors = 0;
      for (int i = 0; i < N_ELEM; i++) begin
        parent_of[i] = ufe_pkg::ELEM_W'(i);
        set_size[i]  = ufe_pkg::SIZE_W'(1);
      end
    endfunction

    // walk up to the root, then hang every node of the path right under it
    function logic [ufe_pkg::ELEM_W-1:0] root_of(logic [ufe_pkg::ELEM_W-1:0] elem);
      logic [ufe_pkg::ELEM_W-1:0] top;
      logic [ufe_pkg::ELEM_W-1:0] walk;
      logic [ufe_pkg::ELEM_W-1:0] nxt;
      top = elem;
      while (parent_of[top] != top) top = parent_of[top];
      walk = elem;
      while (walk != top) begin
        nxt             = parent_of[walk];
        parent_of[walk] = top;
        walk            = nxt;
      end
      return top;
    endfunction

    // accepted request: update the forest and queue the answer it must give
    function void note_request(ufe_pkg::req_t item);
      ufe_pkg::rsp_t              ans;
      logic [ufe_pkg::ELEM_W-1:0] ra;
      logic [ufe_pkg::ELEM_W-1:0] rb;
      logic [ufe_pkg::ELEM_W-1:0] tmp;
      ra                 = root_of(item.first_element);
      ans.root           = ra;
      ans.component_size = set_size[ra];
      ans.merged         = 1'b0;
      if (item.operation == ufe_pkg::OP_UNITE) begin
        rb = root_of(item.second_element);
        // larger set absorbs the smaller, first root keeps a tie
        if (ra != rb) begin
          if (set_size[ra] < set_size[rb]) begin
            tmp = ra;
            ra  = rb;
            rb  = tmp;
          end
          parent_of[rb]      = ra;
          set_size[ra]       = set_size[ra] + set_size[rb];
          ans.root           = ra;
          ans.component_size = set_size[ra];
          ans.merged         = 1'b1;
        end
      end
      expected_answers.push_back(ans);
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // compare one result transfer with the oldest queued answer
    task check_answer(ufe_pkg::rsp_t got);
      ufe_pkg::rsp_t want;
      if (expected_answers.size() == 0) begin
        report($sformatf("result with nothing pending: root=%0d size=%0d merged=%0b",
                         got.root, got.component_size, got.merged));
      end else begin
        want = expected_answers.pop_front();
        if (got.root !== want.root)
          report($sformatf("root %0d, want %0d", got.root, want.root));
        if (got.component_size !== want.component_size)
          report($sformatf("component_size %0d, want %0d",
                           got.component_size, want.component_size));
        if (got.merged !== want.merged)
          report($sformatf("merged %0b, want %0b", got.merged, want.merged));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  ufe_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  ufe_pkg::rsp_t rsp;

  forest_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks = 0;
  int quiet_cycles = 0;

  union_find_engine #(.ELEMENTS(N_ELEM)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic ufe_pkg::req_t pair_item(logic op, int a, int b);
    ufe_pkg::req_t item;
    item.operation      = op;
    item.first_element  = ufe_pkg::ELEM_W'(a);
    item.second_element = ufe_pkg::ELEM_W'(b);
    return item;
  endfunction

  // random request: some pairs drawn from a narrow window to hit shared sets
  function automatic ufe_pkg::req_t random_item();
    int base;
    base = 0;
    if ($urandom_range(99) < 30) begin
      base = $urandom_range(0, N_ELEM - 32);
      return pair_item(($urandom_range(99) < 60) ? ufe_pkg::OP_UNITE : ufe_pkg::OP_FIND,
                       base + $urandom_range(0, 31), base + $urandom_range(0, 31));
    end
    return pair_item(($urandom_range(99) < 60) ? ufe_pkg::OP_UNITE : ufe_pkg::OP_FIND,
                     $urandom_range(0, N_ELEM - 1), $urandom_range(0, N_ELEM - 1));
  endfunction

  // request side: optional gap, then hold valid until the transfer
  task automatic send_item(ufe_pkg::req_t item, int gap);
    if (gap > 0) begin
      @(negedge clk) req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    board.note_request(item);
  endtask

  // sender drops valid and waits for every owed result
  task automatic wait_drained();
    @(negedge clk) req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // response side: long hold on request, otherwise random stalls
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    rsp_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (stall_left == 0) stall_left = pick_gap(recv_idle_pct);
        if (stall_left > 0) begin
          stall_left--;
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  // result transfers go to the scoreboard
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_answer(rsp);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    ufe_pkg::req_t plan [$];
    board         = new();
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: extremes, same-set and same-element unites, ties, deep paths
    plan = '{
      pair_item(ufe_pkg::OP_FIND,  0,    0),
      pair_item(ufe_pkg::OP_FIND,  1023, 1023),
      pair_item(ufe_pkg::OP_UNITE, 0,    1023),
      pair_item(ufe_pkg::OP_UNITE, 1023, 0),
      pair_item(ufe_pkg::OP_UNITE, 5,    5),
      pair_item(ufe_pkg::OP_FIND,  1023, 0),
      pair_item(ufe_pkg::OP_UNITE, 1,    2),
      pair_item(ufe_pkg::OP_UNITE, 3,    1),
      pair_item(ufe_pkg::OP_UNITE, 0,    1),
      pair_item(ufe_pkg::OP_UNITE, 4,    6),
      pair_item(ufe_pkg::OP_UNITE, 7,    8),
      pair_item(ufe_pkg::OP_UNITE, 4,    7),
      pair_item(ufe_pkg::OP_UNITE, 4,    1),
      pair_item(ufe_pkg::OP_FIND,  8,    1023),
      pair_item(ufe_pkg::OP_FIND,  8,    0),
      pair_item(ufe_pkg::OP_UNITE, 682,  341),
      pair_item(ufe_pkg::OP_UNITE, 341,  512),
      pair_item(ufe_pkg::OP_UNITE, 511,  1022),
      pair_item(ufe_pkg::OP_FIND,  1022, 682),
      pair_item(ufe_pkg::OP_UNITE, 8,    341)
    };
    foreach (plan[i]) send_item(plan[i], 0);

    // receiver holds off while requests keep coming, so the engine backs up
    hold_asks++;
    repeat (24) send_item(random_item(), 0);
    wait_drained();

    // random phases with different idling on each side
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 35 : 0;
      recv_idle_pct = (phase >= 2) ? 35 : 0;
      repeat (PHASE_LEN) send_item(random_item(), pick_gap(send_idle_pct));
      if (phase == 1) wait_drained();
    end
    @(negedge clk) req_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
